/* hdl/slfc_pkg.sv */
`default_nettype none
package slfc_pkg;

	localparam int W           = 256;
	localparam int FRAC_BITS   = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int IDX_W       = 21;
	localparam int N_W         = IDX_W + 1;
	localparam int DIFF_W      = 65;
	localparam int PEN_W       = 63;
	localparam int ADDR_W      = 4;

	localparam logic REG_PENALTY = 1'b0;

	localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic                        bad;
		logic [N_W-1:0]              n;
		logic [4:0][DIFF_W-1:0]      d;
	} entry_t;

	function automatic logic [W-1:0] neg256(input logic [W-1:0] a);
		return ~a + W'(1);
	endfunction

	function automatic logic [W-1:0] abs256(input logic [W-1:0] a);
		return a[W-1] ? neg256(a) : a;
	endfunction

	function automatic logic [63:0] sat64(input logic [W-1:0] a);
		logic fits;
		fits = (a[W-1:63] == '0) || (a[W-1:63] == '1);
		if (fits)
			return a[63:0];
		return a[W-1] ? NEG_MIN : POS_MAX;
	endfunction

	function automatic logic [W-1:0] sext65(input logic [DIFF_W-1:0] a);
		return {{(W-DIFF_W){a[DIFF_W-1]}}, a};
	endfunction

endpackage
`default_nettype wire

/* hdl/slfc_item_if.sv */
`default_nettype none
interface slfc_item_if;
	logic               valid;
	logic               ready;
	logic [20:0]        start_index;
	logic [20:0]        end_index;
	logic signed [63:0] before_sum_xy;
	logic signed [63:0] before_sum_x;
	logic signed [63:0] before_sum_y;
	logic signed [63:0] before_sum_xx;
	logic signed [63:0] before_sum_yy;
	logic signed [63:0] end_sum_xy;
	logic signed [63:0] end_sum_x;
	logic signed [63:0] end_sum_y;
	logic signed [63:0] end_sum_xx;
	logic signed [63:0] end_sum_yy;

	modport source (output valid, start_index, end_index, before_sum_xy, before_sum_x,
		before_sum_y, before_sum_xx, before_sum_yy, end_sum_xy, end_sum_x, end_sum_y,
		end_sum_xx, end_sum_yy, input ready);
	modport sink (input valid, start_index, end_index, before_sum_xy, before_sum_x,
		before_sum_y, before_sum_xx, before_sum_yy, end_sum_xy, end_sum_x, end_sum_y,
		end_sum_xx, end_sum_yy, output ready);
endinterface
`default_nettype wire

/* hdl/slfc_result_if.sv */
`default_nettype none
interface slfc_result_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] slope;
	logic signed [63:0] intercept;
	logic signed [63:0] cost;
	logic               cost_infinite;
	logic               degenerate;

	modport source (output valid, slope, intercept, cost, cost_infinite, degenerate,
		input ready);
	modport sink (input valid, slope, intercept, cost, cost_infinite, degenerate,
		output ready);
endinterface
`default_nettype wire

/* hdl/slfc_front.sv */
`default_nettype none
module slfc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	slfc_item_if.sink           item,
	output slfc_pkg::entry_t    ent,
	output logic                ent_valid,
	input  wire logic           ent_ready
);
	logic             vld_s1;
	slfc_pkg::entry_t ent_s1;
	slfc_pkg::entry_t ent_nx;

	assign item.ready = !vld_s1 || ent_ready;
	assign ent        = ent_s1;
	assign ent_valid  = vld_s1;

	always_comb begin
		ent_nx.bad = item.start_index > item.end_index;
		ent_nx.n   = {1'b0, item.end_index} - {1'b0, item.start_index} +
			slfc_pkg::N_W'(1);
		ent_nx.d[0] = {item.end_sum_xy[63], item.end_sum_xy} -
			{item.before_sum_xy[63], item.before_sum_xy};
		ent_nx.d[1] = {item.end_sum_x[63], item.end_sum_x} -
			{item.before_sum_x[63], item.before_sum_x};
		ent_nx.d[2] = {item.end_sum_y[63], item.end_sum_y} -
			{item.before_sum_y[63], item.before_sum_y};
		ent_nx.d[3] = {item.end_sum_xx[63], item.end_sum_xx} -
			{item.before_sum_xx[63], item.before_sum_xx};
		ent_nx.d[4] = {item.end_sum_yy[63], item.end_sum_yy} -
			{item.before_sum_yy[63], item.before_sum_yy};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			ent_s1 <= ent_nx;
		end
	end
endmodule
`default_nettype wire

/* hdl/slfc_queue.sv */
`default_nettype none
module slfc_queue #(
	parameter int DEPTH = slfc_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire slfc_pkg::entry_t  wr_data,
	input  wire logic              wr_valid,
	output logic                   wr_ready,
	output slfc_pkg::entry_t       rd_data,
	output logic                   rd_valid,
	input  wire logic              rd_ready
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	slfc_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             push, pop;

	assign wr_ready = cnt_q != CW'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end
endmodule
`default_nettype wire

/* hdl/slfc_back.sv */
`default_nettype none
module slfc_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire slfc_pkg::entry_t  q_data,
	input  wire logic              q_valid,
	output logic                   q_ready,
	input  wire logic [62:0]       penalty,
	slfc_result_if.source          result
);
	localparam int W = slfc_pkg::W;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_MRUN = 5'd1;
	localparam logic [4:0] ST_DRUN = 5'd2;
	localparam logic [4:0] ST_P1   = 5'd3;
	localparam logic [4:0] ST_P2   = 5'd4;
	localparam logic [4:0] ST_P3   = 5'd5;
	localparam logic [4:0] ST_P4   = 5'd6;
	localparam logic [4:0] ST_DL1  = 5'd7;
	localparam logic [4:0] ST_P5   = 5'd8;
	localparam logic [4:0] ST_P6   = 5'd9;
	localparam logic [4:0] ST_DL2  = 5'd10;
	localparam logic [4:0] ST_P7   = 5'd11;
	localparam logic [4:0] ST_P8   = 5'd12;
	localparam logic [4:0] ST_P9   = 5'd13;
	localparam logic [4:0] ST_P10  = 5'd14;
	localparam logic [4:0] ST_P11  = 5'd15;
	localparam logic [4:0] ST_P12  = 5'd16;
	localparam logic [4:0] ST_P13  = 5'd17;
	localparam logic [4:0] ST_P14  = 5'd18;
	localparam logic [4:0] ST_P15  = 5'd19;
	localparam logic [4:0] ST_P16  = 5'd20;
	localparam logic [4:0] ST_P17  = 5'd21;
	localparam logic [4:0] ST_P18  = 5'd22;
	localparam logic [4:0] ST_DONE = 5'd23;

	logic [4:0]   st_q, ret_q;
	logic [W-1:0] d_q [5];
	logic [W-1:0] sc_q, num_q, den_q, x_q, t_q;
	logic [slfc_pkg::N_W-1:0] n_q;
	logic [63:0]  k_q, a_q, cost_q;
	logic         cinf_q, degen_q, out_vld_q;
	logic [63:0]  slope_q, icpt_q, ocost_q;
	logic         ocinf_q, odegen_q;

	// shift-add multiplier
	logic [W-1:0] mc_q, mp_q, acc_q;
	// restoring divider
	logic [W-1:0] dn_q, dv_q, rem_q, quo_q;
	logic         dneg_q;
	logic [7:0]   cnt_q;

	logic [W-1:0] d_in [5];
	logic [W-1:0] sc_in, k_ext, a_ext, mul_sum, den_new, x_new, sq;
	logic [W:0]   r2, r_sub;
	logic         ge;
	logic [63:0]  sat_q;
	logic         ml_go, dv_go;
	logic [W-1:0] ml_a, ml_b, dv_a, dv_b;
	logic [4:0]   go_ret;

	assign q_ready          = st_q == ST_IDLE;
	assign result.valid     = out_vld_q;
	assign result.slope     = slope_q;
	assign result.intercept = icpt_q;
	assign result.cost      = ocost_q;
	assign result.cost_infinite = ocinf_q;
	assign result.degenerate    = odegen_q;

	always_comb begin
		for (int j = 0; j < 5; j++) begin
			d_in[j] = slfc_pkg::sext65(q_data.d[j]);
		end
		sc_in   = W'(q_data.n) << slfc_pkg::FRAC_BITS;
		k_ext   = {{(W-64){k_q[63]}}, k_q};
		a_ext   = {{(W-64){a_q[63]}}, a_q};
		mul_sum = acc_q + mc_q;
		den_new = den_q - acc_q;
		x_new   = (d_q[2] << 32) - acc_q;
		r2      = {rem_q, dn_q[W-1]};
		r_sub   = r2 - {1'b0, dv_q};
		ge      = !r_sub[W];
		sq      = dneg_q ? slfc_pkg::neg256(quo_q) : quo_q;
		sat_q   = slfc_pkg::sat64(sq);
	end

	always_comb begin
		ml_go  = 1'b0;
		dv_go  = 1'b0;
		ml_a   = d_q[1];
		ml_b   = d_q[1];
		dv_a   = num_q << 32;
		dv_b   = den_q;
		go_ret = ST_IDLE;
		unique case (st_q)
			ST_IDLE: begin
				ml_go  = q_valid && !q_data.bad;
				ml_a   = sc_in;
				ml_b   = d_in[0];
				go_ret = ST_P1;
			end
			ST_P1: begin
				ml_go = 1'b1; ml_a = d_q[1]; ml_b = d_q[2]; go_ret = ST_P2;
			end
			ST_P2: begin
				ml_go = 1'b1; ml_a = sc_q; ml_b = d_q[3]; go_ret = ST_P3;
			end
			ST_P3: begin
				ml_go = 1'b1; ml_a = d_q[1]; ml_b = d_q[1]; go_ret = ST_P4;
			end
			ST_DL1: begin
				dv_go = 1'b1; dv_a = num_q << 32; dv_b = den_q; go_ret = ST_P5;
			end
			ST_P5: begin
				ml_go = 1'b1; ml_a = {{(W-64){sat_q[63]}}, sat_q}; ml_b = d_q[1];
				go_ret = ST_P6;
			end
			ST_DL2: begin
				dv_go = 1'b1; dv_a = x_q; dv_b = sc_q; go_ret = ST_P7;
			end
			ST_P7: begin
				ml_go = 1'b1; ml_a = k_ext; ml_b = k_ext; go_ret = ST_P8;
			end
			ST_P8: begin
				ml_go = 1'b1; ml_a = d_q[3]; ml_b = acc_q; go_ret = ST_P9;
			end
			ST_P9: begin
				ml_go = 1'b1; ml_a = k_ext; ml_b = a_ext; go_ret = ST_P10;
			end
			ST_P10: begin
				ml_go = 1'b1; ml_a = d_q[1]; ml_b = acc_q; go_ret = ST_P11;
			end
			ST_P11: begin
				ml_go = 1'b1; ml_a = a_ext; ml_b = a_ext; go_ret = ST_P12;
			end
			ST_P12: begin
				ml_go = 1'b1; ml_a = sc_q; ml_b = acc_q; go_ret = ST_P13;
			end
			ST_P13: begin
				ml_go = 1'b1; ml_a = d_q[0]; ml_b = k_ext; go_ret = ST_P14;
			end
			ST_P14: begin
				ml_go = 1'b1; ml_a = d_q[2]; ml_b = a_ext; go_ret = ST_P15;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			ret_q     <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			if (st_q == ST_DONE && (!out_vld_q || result.ready)) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			if (ml_go) begin
				st_q  <= ST_MRUN;
				ret_q <= go_ret;
			end else if (dv_go) begin
				st_q  <= ST_DRUN;
				ret_q <= go_ret;
			end else begin
				unique case (st_q)
					ST_IDLE: begin
						if (q_valid) begin
							st_q <= ST_DONE;
						end
					end
					ST_MRUN: begin
						if (mp_q[W-1:1] == '0) begin
							st_q <= ret_q;
						end
					end
					ST_DRUN: begin
						if (cnt_q == 8'hFF) begin
							st_q <= ret_q;
						end
					end
					ST_P4: st_q <= (den_new == '0) ? ST_DONE : ST_DL1;
					ST_P6: st_q <= ST_DL2;
					ST_P15: st_q <= ST_P16;
					ST_P16: st_q <= ST_P17;
					ST_P17: st_q <= ST_P18;
					ST_P18: st_q <= ST_DONE;
					ST_DONE: begin
						if (!out_vld_q || result.ready) begin
							st_q <= ST_IDLE;
						end
					end
					default: st_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ml_go) begin
			mc_q  <= ml_a;
			mp_q  <= ml_b;
			acc_q <= '0;
		end else if (st_q == ST_MRUN) begin
			if (mp_q[0]) begin
				acc_q <= mul_sum;
			end
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
		if (dv_go) begin
			dn_q   <= slfc_pkg::abs256(dv_a);
			dv_q   <= slfc_pkg::abs256(dv_b);
			dneg_q <= dv_a[W-1] ^ dv_b[W-1];
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
		end else if (st_q == ST_DRUN) begin
			rem_q <= ge ? r_sub[W-1:0] : r2[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
			dn_q  <= dn_q << 1;
			cnt_q <= cnt_q + 8'd1;
		end
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					for (int j = 0; j < 5; j++) begin
						d_q[j] <= d_in[j];
					end
					sc_q    <= sc_in;
					n_q     <= q_data.n;
					k_q     <= '0;
					a_q     <= '0;
					cost_q  <= '0;
					cinf_q  <= 1'b0;
					degen_q <= q_data.bad;
				end
			end
			ST_P1: num_q <= acc_q;
			ST_P2: num_q <= num_q - acc_q;
			ST_P3: den_q <= acc_q;
			ST_P4: begin
				den_q <= den_new;
				if (den_new == '0) begin
					cost_q  <= slfc_pkg::POS_MAX;
					cinf_q  <= n_q == slfc_pkg::N_W'(1);
					degen_q <= 1'b1;
				end
			end
			ST_P5: k_q <= sat_q;
			ST_P6: x_q <= x_new;
			ST_P7: a_q <= sat_q;
			ST_P9: t_q <= acc_q;
			ST_P11: t_q <= t_q + (acc_q << 1);
			ST_P13: t_q <= t_q + acc_q;
			ST_P14: t_q <= t_q - (acc_q << 33);
			ST_P15: t_q <= t_q - (acc_q << 33);
			ST_P16: t_q <= t_q + (d_q[4] << 64);
			ST_P17: t_q <= t_q + (W'(penalty) << 64);
			ST_P18: begin
				if (n_q == slfc_pkg::N_W'(1)) begin
					cost_q <= slfc_pkg::POS_MAX;
					cinf_q <= 1'b1;
				end else begin
					cost_q <= slfc_pkg::sat64({{64{t_q[W-1]}}, t_q[W-1:64]});
				end
			end
			ST_DONE: begin
				if (!out_vld_q || result.ready) begin
					slope_q  <= k_q;
					icpt_q   <= a_q;
					ocost_q  <= cost_q;
					ocinf_q  <= cinf_q;
					odegen_q <= degen_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

/* hdl/segment_linear_fit_cost.sv */
// channel  | role            | handshake
// item     | segment in      | valid/ready, taken when both high
// result   | fit and cost    | valid/ready, taken when both high
// apb      | penalty reg     | psel/penable/pwrite, pready tied high
//
// The front stage takes a transaction every cycle while the queue has room.
// The back end runs one segment at a time on a shift-add multiplier and a
// restoring divider of 256 bit steps each (the multiplier stops early once
// its remaining operand bits are zero): up to 13 multiplies plus 2 divides
// per segment; a start-after-end segment skips the arithmetic. Reset clears
// control state and the penalty. The result register lets the back end
// finish its next segment while a result waits.
`default_nettype none
module segment_linear_fit_cost #(
	parameter int QUEUE_DEPTH = slfc_pkg::QUEUE_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [slfc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [63:0]                 pwdata,
	output logic [63:0]                      prdata,
	output logic                             pready,
	slfc_item_if.sink                        item,
	slfc_result_if.source                    result
);
	logic [slfc_pkg::PEN_W-1:0] pen_q;
	slfc_pkg::entry_t           f_data, q_data;
	logic                       f_valid, f_ready, q_valid, q_ready;

	assign pready = 1'b1;
	assign prdata = (paddr[3] == slfc_pkg::REG_PENALTY) ? {1'b0, pen_q} : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_q <= '0;
		end else if (psel && penable && pwrite && pready &&
			paddr[3] == slfc_pkg::REG_PENALTY) begin
			pen_q <= pwdata[slfc_pkg::PEN_W-1:0];
		end
	end

	slfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.ent       (f_data),
		.ent_valid (f_valid),
		.ent_ready (f_ready)
	);

	slfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (f_data),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_data  (q_data),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	slfc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_data),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.penalty (pen_q),
		.result  (result)
	);

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.degenerate |-> result.slope == 0 && result.intercept == 0)
		else $error("degenerate result with nonzero fit");
	a_inf_cost: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.cost_infinite |-> result.cost == slfc_pkg::POS_MAX)
		else $error("one-point segment without saturated cost");
	a_queue_stall: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && !f_ready |=> f_valid)
		else $error("front stage dropped a transaction");
`endif
endmodule
`default_nettype wire
